### rtl/upt_pkg.sv
// Package for the updatable priority task table.
// Holds table sizes, the opcode and entry types, and the command and status
// structs between the controller and the datapath. No dependencies.
package upt_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned PriBits   = 16;
  localparam int unsigned IdxBits   = $clog2(Capacity);
  localparam int unsigned FieldBits = 16;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpEdit   = 2'd1,
    OpRemove = 2'd2,
    OpExec   = 2'd3
  } upt_op_e;

  typedef struct packed {
    logic [IdBits-1:0]  user;
    logic [IdBits-1:0]  key;
    logic [PriBits-1:0] pri;
  } upt_entry_t;

  localparam int unsigned EntryBits = $bits(upt_entry_t);

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic load_out;
  } upt_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_result;
    logic out_free;
  } upt_sts_t;

endpackage

### rtl/upt_if.sv
// Channel interfaces for the updatable priority task table.
// One interface for operation items and one for results; uses upt_pkg.
interface upt_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [upt_pkg::FieldBits-1:0]   user_id;
  logic [upt_pkg::FieldBits-1:0]   task_id;
  logic [upt_pkg::FieldBits-1:0]   priority_req;

  modport source (output valid, opcode, user_id, task_id, priority_req, input ready);
  modport sink (input valid, opcode, user_id, task_id, priority_req, output ready);
endinterface

interface upt_out_if;
  logic                            valid;
  logic                            ready;
  logic [upt_pkg::FieldBits-1:0]   served_user;
  logic                            queue_empty;
  logic                            add_dropped;

  modport source (output valid, served_user, queue_empty, add_dropped, input ready);
  modport sink (input valid, served_user, queue_empty, add_dropped, output ready);
endinterface

### rtl/upt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module upt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/upt_datapath.sv
// Datapath of the updatable priority task table: entry RAM, valid bits,
// scan counter, key match, free slot and maximum trackers, result register.
// Uses upt_pkg and upt_ram.
module upt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  upt_pkg::upt_cmd_t             cmd_i,
  output upt_pkg::upt_sts_t             sts_o,
  input  logic [1:0]                    opcode_i,
  input  logic [upt_pkg::FieldBits-1:0] user_id_i,
  input  logic [upt_pkg::FieldBits-1:0] task_id_i,
  input  logic [upt_pkg::FieldBits-1:0] priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [upt_pkg::FieldBits-1:0] served_user_o,
  output logic                          queue_empty_o,
  output logic                          add_dropped_o
);

  upt_pkg::upt_op_e                   op_q;
  logic [upt_pkg::IdBits-1:0]         user_q, key_q;
  logic [upt_pkg::PriBits-1:0]        pri_q;

  logic [upt_pkg::IdxBits-1:0]        cnt_q, cnt_d;
  logic                               rd_vld_q;
  logic [upt_pkg::IdxBits-1:0]        rd_idx_q;
  upt_pkg::upt_entry_t                rd_ent;
  logic [upt_pkg::EntryBits-1:0]      rdata;

  logic [upt_pkg::Capacity-1:0]       vld_q, vld_d;
  logic                               slot_v;

  logic                               hit_q, hit_d;
  logic [upt_pkg::IdxBits-1:0]        hit_idx_q, hit_idx_d;
  logic [upt_pkg::IdBits-1:0]         hit_user_q, hit_user_d;
  logic                               free_q, free_d;
  logic [upt_pkg::IdxBits-1:0]        free_idx_q, free_idx_d;
  logic                               best_q, best_d;
  logic [upt_pkg::IdxBits-1:0]        best_idx_q, best_idx_d;
  logic [upt_pkg::IdBits-1:0]         best_user_q, best_user_d;
  logic [upt_pkg::IdBits-1:0]         best_key_q, best_key_d;
  logic [upt_pkg::PriBits-1:0]        best_pri_q, best_pri_d;

  logic                               we;
  logic [upt_pkg::IdxBits-1:0]        waddr;
  upt_pkg::upt_entry_t                wdata;

  logic                               out_valid_q, out_valid_d;
  logic [upt_pkg::FieldBits-1:0]      served_q;
  logic                               empty_q, dropped_q;
  logic                               need_result;

  upt_ram #(
    .Width(upt_pkg::EntryBits),
    .Depth(upt_pkg::Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.scan),
    .raddr_i(cnt_q),
    .rdata_o(rdata)
  );

  assign rd_ent = upt_pkg::upt_entry_t'(rdata);
  assign slot_v = vld_q[rd_idx_q];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.capture) begin
      cnt_d = '0;
    end else if (cmd_i.scan) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Scan trackers update as each slot's read data comes back.
  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_user_d  = hit_user_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_user_d = best_user_q;
    best_key_d  = best_key_q;
    best_pri_d  = best_pri_q;
    if (cmd_i.capture) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      best_d = 1'b0;
    end else if (rd_vld_q) begin
      if (slot_v && !hit_q && rd_ent.key == key_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = rd_idx_q;
        hit_user_d = rd_ent.user;
      end
      if (!slot_v && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
      if (slot_v && (!best_q || rd_ent.pri > best_pri_q ||
                     (rd_ent.pri == best_pri_q && rd_ent.key > best_key_q))) begin
        best_d      = 1'b1;
        best_idx_d  = rd_idx_q;
        best_user_d = rd_ent.user;
        best_key_d  = rd_ent.key;
        best_pri_d  = rd_ent.pri;
      end
    end
  end

  // Table update at the end of the scan.
  always_comb begin
    we    = 1'b0;
    waddr = hit_idx_q;
    wdata = '{user: user_q, key: key_q, pri: pri_q};
    vld_d = vld_q;
    if (cmd_i.commit) begin
      case (op_q)
        upt_pkg::OpAdd: begin
          if (hit_q) begin
            we = 1'b1;
          end else if (free_q) begin
            we           = 1'b1;
            waddr        = free_idx_q;
            vld_d[free_idx_q] = 1'b1;
          end
        end
        upt_pkg::OpEdit: begin
          if (hit_q) begin
            we    = 1'b1;
            wdata = '{user: hit_user_q, key: key_q, pri: pri_q};
          end
        end
        upt_pkg::OpRemove: begin
          if (hit_q) begin
            vld_d[hit_idx_q] = 1'b0;
          end
        end
        upt_pkg::OpExec: begin
          if (best_q) begin
            vld_d[best_idx_q] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign need_result = (op_q == upt_pkg::OpExec) ||
                       (op_q == upt_pkg::OpAdd && !hit_q && !free_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      vld_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_vld_q    <= cmd_i.scan;
      vld_q       <= vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= cnt_q;
    hit_idx_q   <= hit_idx_d;
    hit_user_q  <= hit_user_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_user_q <= best_user_d;
    best_key_q  <= best_key_d;
    best_pri_q  <= best_pri_d;
    if (cmd_i.capture) begin
      op_q   <= upt_pkg::upt_op_e'(opcode_i);
      user_q <= upt_pkg::IdBits'(user_id_i);
      key_q  <= upt_pkg::IdBits'(task_id_i);
      pri_q  <= upt_pkg::PriBits'(priority_req_i);
    end
    if (cmd_i.load_out) begin
      served_q  <= (op_q == upt_pkg::OpExec && best_q) ?
                   upt_pkg::FieldBits'(best_user_q) : '0;
      empty_q   <= (op_q == upt_pkg::OpExec) && !best_q;
      dropped_q <= (op_q == upt_pkg::OpAdd);
    end
  end

  assign sts_o.scan_last   = (cnt_q == upt_pkg::IdxBits'(upt_pkg::Capacity - 1));
  assign sts_o.need_result = need_result;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign served_user_o = served_q;
  assign queue_empty_o = empty_q;
  assign add_dropped_o = dropped_q;

endmodule

### rtl/upt_ctrl.sv
// Controller of the updatable priority task table: sequences capture, slot
// scan, table update and result hand-off. Uses upt_pkg.
module upt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  upt_pkg::upt_sts_t sts_i,
  output upt_pkg::upt_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StDrain  = 5'b00100,
    StCommit = 5'b01000,
    StResult = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.need_result ? StResult : StIdle;
      end
      StResult: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/updatable_priority_task_table.sv
// Top level of the updatable priority task table.
// Instantiates upt_ctrl and upt_datapath; uses upt_pkg and the upt_in_if and
// upt_out_if channel interfaces.
//
// An operation is taken only while the controller is idle. It is followed by a
// scan of every slot of the entry RAM through its single read port, one slot
// per cycle. Between two operation transfers the controller passes through the
// scan, a drain state for the last read data, a commit state for the table
// update and the idle state in which the next transfer is taken. Add-dropped
// and execute-top operations also pass through a result state that loads the
// result register, which drives the output valid. A result may wait in
// its register while the next operation is scanned; a second result waits
// until the first one is transferred, and so does the input. The valid bits
// are flip-flops cleared by reset, so the block is ready right after reset.
module updatable_priority_task_table (
  input  logic   clk_i,
  input  logic   rst_ni,
  upt_in_if.sink    in_chan_i,
  upt_out_if.source out_chan_o
);

  upt_pkg::upt_cmd_t cmd;
  upt_pkg::upt_sts_t sts;

  upt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_chan_i.valid),
    .in_ready_o(in_chan_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  upt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_chan_i.opcode),
    .user_id_i     (in_chan_i.user_id),
    .task_id_i     (in_chan_i.task_id),
    .priority_req_i(in_chan_i.priority_req),
    .out_valid_o   (out_chan_o.valid),
    .out_ready_i   (out_chan_o.ready),
    .served_user_o (out_chan_o.served_user),
    .queue_empty_o (out_chan_o.queue_empty),
    .add_dropped_o (out_chan_o.add_dropped)
  );

endmodule
